// ===== hw/rtl/hsvc_pkg.sv =====
// Shared types and constants for the HSV/RGB color converter.
// No dependencies.
package hsvc_pkg;

    localparam int unsigned HUE_W = 13;
    localparam int unsigned CH_W  = 8;

    // hue units: 960 per 60-degree sector, 5760 per turn
    localparam logic [HUE_W-1:0] SECTOR_SPAN = 13'd960;
    localparam logic [HUE_W-1:0] HUE_TURN    = 13'd5760;
    localparam logic [17:0]      FULL_SCALE  = 18'd244800;  // 255 * 960

    // floor(n / 244800) == (n * FULL_RECIP) >> FULL_RECIP_SH for any 26-bit n
    localparam logic [26:0]      FULL_RECIP    = 27'd71863506;
    localparam int unsigned      FULL_RECIP_SH = 44;

    // pipelined divider geometry
    localparam int unsigned DIV_NW = 26;
    localparam int unsigned DIV_DW = 18;
    localparam int unsigned DIV_QW = 10;
    localparam int unsigned FRONT_STAGES = 3;

    typedef enum logic [1:0] {
        MAX_RED   = 2'd0,
        MAX_GREEN = 2'd1,
        MAX_BLUE  = 2'd2
    } t_maxsel;

    typedef struct packed {
        logic             kind;
        logic [CH_W-1:0]  red_in;
        logic [CH_W-1:0]  green_in;
        logic [CH_W-1:0]  blue_in;
        logic [HUE_W-1:0] hue_in;
        logic [CH_W-1:0]  sat_in;
        logic [CH_W-1:0]  bright_in;
        logic [CH_W-1:0]  alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0]  red_out;
        logic [CH_W-1:0]  green_out;
        logic [CH_W-1:0]  blue_out;
        logic [HUE_W-1:0] hue_out;
        logic [CH_W-1:0]  sat_out;
        logic [CH_W-1:0]  bright_out;
        logic [CH_W-1:0]  alpha_out;
    } t_pix_out;

    // control that rides alongside the divider lanes
    typedef struct packed {
        t_pix_in  item;
        logic [2:0] sector;
        t_maxsel  maxsel;
        logic     hneg;
        logic     grey;
    } t_side;

endpackage

// ===== hw/rtl/hsvc_divpipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Uses no package. Caller guarantees num >> QW < den.
module hsvc_divpipe #(
    parameter int unsigned NW = 26,
    parameter int unsigned DW = 18,
    parameter int unsigned QW = 10
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    logic [DW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [DW:0]   trial;
        logic [DW-1:0] n_rem;
        logic          qbit;

        if (k == 0) begin : g_first
            assign rem_in = DW'(i_num[NW-1:QW]);
            assign den_in = i_den;
            assign low_in = i_num[QW-1:0];
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign low_in = r_low[k-1];
            assign quo_in = r_quo[k-1];
        end

        always_comb begin
            trial = {rem_in, low_in[QW-1-k]};
            qbit  = (trial >= {1'b0, den_in});
            n_rem = qbit ? DW'(trial - {1'b0, den_in}) : DW'(trial);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= den_in;
                r_low[k] <= low_in;
                r_quo[k] <= {quo_in[QW-2:0], qbit};
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

// ===== hw/rtl/hsvc_front.sv =====
// Front end: min/max, sector split, products and divider numerators.
// Three register stages; depends on hsvc_pkg.
module hsvc_front (
    input  logic             i_clk,
    input  logic             i_en,
    input  hsvc_pkg::t_pix_in i_item,
    output hsvc_pkg::t_side  o_side,
    output logic [hsvc_pkg::DIV_NW-1:0] o_num [5],
    output logic [hsvc_pkg::DIV_DW-1:0] o_den [2]
);
    // lanes: 0 sat, 1 hue, 2 p, 3 q, 4 t; only sat and hue have a variable divisor

    // ---- stage A
    hsvc_pkg::t_pix_in r_a_item;
    logic [12:0]       r_a_h;
    logic [7:0]        r_a_mx, r_a_d, r_a_mag;
    logic              r_a_neg;
    hsvc_pkg::t_maxsel r_a_sel;

    logic [12:0]       n_a_h;
    logic [7:0]        n_a_mx, n_a_mn, n_a_mag;
    logic              n_a_neg;
    hsvc_pkg::t_maxsel n_a_sel;
    logic [7:0]        cr, cg, cb;

    always_comb begin
        cr = i_item.red_in;
        cg = i_item.green_in;
        cb = i_item.blue_in;
        n_a_h = (i_item.hue_in >= hsvc_pkg::HUE_TURN) ?
                i_item.hue_in - hsvc_pkg::HUE_TURN : i_item.hue_in;
        n_a_mx = (cr > cg) ? cr : cg;
        if (cb > n_a_mx) n_a_mx = cb;
        n_a_mn = (cr < cg) ? cr : cg;
        if (cb < n_a_mn) n_a_mn = cb;
        priority if (cr >= cg && cr >= cb) begin
            n_a_sel = hsvc_pkg::MAX_RED;
            n_a_neg = cg < cb;
            n_a_mag = n_a_neg ? cb - cg : cg - cb;
        end else if (cg >= cb) begin
            n_a_sel = hsvc_pkg::MAX_GREEN;
            n_a_neg = cb < cr;
            n_a_mag = n_a_neg ? cr - cb : cb - cr;
        end else begin
            n_a_sel = hsvc_pkg::MAX_BLUE;
            n_a_neg = cr < cg;
            n_a_mag = n_a_neg ? cg - cr : cr - cg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_item <= i_item;
            r_a_h    <= n_a_h;
            r_a_mx   <= n_a_mx;
            r_a_d    <= n_a_mx - n_a_mn;
            r_a_mag  <= n_a_mag;
            r_a_neg  <= n_a_neg;
            r_a_sel  <= n_a_sel;
        end
    end

    // ---- stage B
    hsvc_pkg::t_side r_b_side;
    logic [7:0]  r_b_mx, r_b_d;
    logic [15:0] r_b_pnum, r_b_snum;
    logic [17:0] r_b_fs, r_b_gs, r_b_hnum;

    logic [2:0]  n_b_sec;
    logic [12:0] sec_base;
    logic [9:0]  f, g;
    logic [7:0]  s, v;

    always_comb begin
        s = r_a_item.sat_in;
        v = r_a_item.bright_in;
        priority if (r_a_h >= 13'd4800) n_b_sec = 3'd5;
        else if (r_a_h >= 13'd3840)     n_b_sec = 3'd4;
        else if (r_a_h >= 13'd2880)     n_b_sec = 3'd3;
        else if (r_a_h >= 13'd1920)     n_b_sec = 3'd2;
        else if (r_a_h >= 13'd960)      n_b_sec = 3'd1;
        else                            n_b_sec = 3'd0;
        sec_base = 13'(n_b_sec) * hsvc_pkg::SECTOR_SPAN;
        f = 10'(r_a_h - sec_base);
        g = 10'(hsvc_pkg::SECTOR_SPAN) - f;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_side.item   <= r_a_item;
            r_b_side.sector <= n_b_sec;
            r_b_side.maxsel <= r_a_sel;
            r_b_side.hneg   <= r_a_neg;
            r_b_side.grey   <= (r_a_d == 8'd0);
            r_b_mx   <= r_a_mx;
            r_b_d    <= r_a_d;
            r_b_pnum <= 16'(v) * 16'(8'd255 - s) + 16'd127;
            r_b_fs   <= 18'(f) * 18'(s);
            r_b_gs   <= 18'(g) * 18'(s);
            r_b_hnum <= 18'(r_a_mag) * 18'd960 + 18'(r_a_d >> 1);
            r_b_snum <= 16'(r_a_d) * 16'd255 + 16'(r_a_mx >> 1);
        end
    end

    // ---- stage C
    hsvc_pkg::t_side r_c_side;
    logic [hsvc_pkg::DIV_NW-1:0] r_c_num [5];
    logic [hsvc_pkg::DIV_DW-1:0] r_c_den [2];
    logic [7:0] bv;

    assign bv = r_b_side.item.bright_in;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_side   <= r_b_side;
            r_c_num[0] <= 26'(r_b_snum);
            r_c_den[0] <= (r_b_mx == 8'd0) ? 18'd1 : 18'(r_b_mx);
            r_c_num[1] <= 26'(r_b_hnum);
            r_c_den[1] <= (r_b_d == 8'd0) ? 18'd1 : 18'(r_b_d);
            r_c_num[2] <= 26'(r_b_pnum);
            r_c_num[3] <= 26'(bv) * 26'(hsvc_pkg::FULL_SCALE - r_b_fs)
                          + 26'(hsvc_pkg::FULL_SCALE >> 1);
            r_c_num[4] <= 26'(bv) * 26'(hsvc_pkg::FULL_SCALE - r_b_gs)
                          + 26'(hsvc_pkg::FULL_SCALE >> 1);
        end
    end

    assign o_side = r_c_side;
    assign o_num  = r_c_num;
    assign o_den  = r_c_den;

endmodule

// ===== hw/rtl/hsv_rgb_color_converter.sv =====
// Top level of the HSV/RGB converter: front end, two divider lanes, result stage.
// Depends on hsvc_pkg, hsvc_front, hsvc_divpipe.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+------------------
//  in      | i_in_valid | o_in_ready  | i_in  (t_pix_in)
//  out     | o_out_valid| i_out_ready | o_out (t_pix_out)
//
// One pixel per cycle unless the output stalls. The path has three front stages, ten divider
// stages (one quotient bit each), one output register. p, q and t divide by
// constants via reciprocal multiply and ride a delay line matching the divider.
// Reset clears the valid bits only. The whole pipeline holds while a result
// waits on the output and i_out_ready is low; bubbles are not squeezed out.
module hsv_rgb_color_converter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hsvc_pkg::t_pix_in  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hsvc_pkg::t_pix_out o_out
);
    localparam int unsigned NSTG = hsvc_pkg::FRONT_STAGES + hsvc_pkg::DIV_QW;
    localparam int unsigned QW   = hsvc_pkg::DIV_QW;

    logic en;
    logic [NSTG-1:0] r_vld;
    logic r_out_valid, r_out_kind;
    hsvc_pkg::t_pix_out r_out, n_out;

    hsvc_pkg::t_side side_c;
    hsvc_pkg::t_side r_side [QW];
    logic [hsvc_pkg::DIV_NW-1:0] num [5];
    logic [hsvc_pkg::DIV_DW-1:0] den [2];
    logic [QW-1:0] quo [2];

    // constant-divisor lanes: p, q, t
    logic [15:0]      p_sum;
    logic [52:0]      q_prod, t_prod;
    logic [2:0][7:0]  pqt_c;
    logic [2:0][7:0]  r_pqt [QW];

    assign en = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    hsvc_front u_front (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_item (i_in),
        .o_side (side_c),
        .o_num  (num),
        .o_den  (den)
    );

    for (genvar l = 0; l < 2; l++) begin : g_lane
        hsvc_divpipe #(
            .NW (hsvc_pkg::DIV_NW),
            .DW (hsvc_pkg::DIV_DW),
            .QW (QW)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (num[l]),
            .i_den (den[l]),
            .o_quo (quo[l])
        );
    end

    // n/255 == (n + (n >> 8) + 1) >> 8 for n below 65535
    always_comb begin
        p_sum    = num[2][15:0] + {8'd0, num[2][15:8]} + 16'd1;
        q_prod   = 53'(num[3]) * 53'(hsvc_pkg::FULL_RECIP);
        t_prod   = 53'(num[4]) * 53'(hsvc_pkg::FULL_RECIP);
        pqt_c[0] = p_sum[15:8];
        pqt_c[1] = q_prod[hsvc_pkg::FULL_RECIP_SH +: 8];
        pqt_c[2] = t_prod[hsvc_pkg::FULL_RECIP_SH +: 8];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= side_c;
            r_pqt[0]  <= pqt_c;
            for (int k = 1; k < QW; k++) begin
                r_side[k] <= r_side[k-1];
                r_pqt[k]  <= r_pqt[k-1];
            end
        end
    end

    // result stage
    hsvc_pkg::t_side sd;
    logic [7:0]  v, p, q, t;
    logic [12:0] hq, hue;

    always_comb begin
        sd = r_side[QW-1];
        v  = sd.item.bright_in;
        p  = r_pqt[QW-1][0];
        q  = r_pqt[QW-1][1];
        t  = r_pqt[QW-1][2];
        hq = 13'(quo[1]);
        n_out.alpha_out  = sd.item.alpha_in;
        n_out.red_out    = sd.item.red_in;
        n_out.green_out  = sd.item.green_in;
        n_out.blue_out   = sd.item.blue_in;
        n_out.hue_out    = sd.item.hue_in;
        n_out.sat_out    = sd.item.sat_in;
        n_out.bright_out = sd.item.bright_in;
        unique case (sd.maxsel)
            hsvc_pkg::MAX_RED:
                hue = !sd.hneg ? hq : (hq == 13'd0 ? 13'd0 : hsvc_pkg::HUE_TURN - hq);
            hsvc_pkg::MAX_GREEN:
                hue = sd.hneg ? 13'd1920 - hq : 13'd1920 + hq;
            default:
                hue = sd.hneg ? 13'd3840 - hq : 13'd3840 + hq;
        endcase
        if (sd.item.kind) begin
            n_out.bright_out = (sd.item.red_in > sd.item.green_in) ?
                               sd.item.red_in : sd.item.green_in;
            if (sd.item.blue_in > n_out.bright_out) n_out.bright_out = sd.item.blue_in;
            n_out.sat_out = quo[0][7:0];
            n_out.hue_out = sd.grey ? 13'd0 : hue;
        end else begin
            unique case (sd.sector)
                3'd0: {n_out.red_out, n_out.green_out, n_out.blue_out} = {v, t, p};
                3'd1: {n_out.red_out, n_out.green_out, n_out.blue_out} = {q, v, p};
                3'd2: {n_out.red_out, n_out.green_out, n_out.blue_out} = {p, v, t};
                3'd3: {n_out.red_out, n_out.green_out, n_out.blue_out} = {p, q, v};
                3'd4: {n_out.red_out, n_out.green_out, n_out.blue_out} = {t, p, v};
                default: {n_out.red_out, n_out.green_out, n_out.blue_out} = {v, p, q};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[NSTG-2:0], i_in_valid};
            r_out_valid <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out      <= n_out;
            r_out_kind <= sd.item.kind;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // assertions
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(r_vld))
        else $error("pipeline moved during stall");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_out_kind) |-> (o_out.hue_out < hsvc_pkg::HUE_TURN))
        else $error("computed hue out of range");

    a_grey_hsv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !r_out_kind && o_out.sat_out == 8'd0) |->
        (o_out.red_out == o_out.bright_out && o_out.green_out == o_out.bright_out
         && o_out.blue_out == o_out.bright_out))
        else $error("zero saturation gave non-grey pixel");

endmodule
